// File: sv/blg_pkg.sv
`timescale 1ns / 1ps

package blg_pkg;

    // field widths fixed by the interface
    localparam int ADC_W   = 10;
    localparam int LEVEL_W = 3;
    localparam int AVG_W   = 10;
    localparam int THR_W   = 10;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_THR  = 2'd2;

    // threshold values after reset
    localparam logic [THR_W-1:0] FULL_THR_RST = 10'd828;
    localparam logic [THR_W-1:0] HIGH_THR_RST = 10'd773;
    localparam logic [THR_W-1:0] MID_THR_RST  = 10'd718;

    // reported level codes
    localparam logic [LEVEL_W-1:0] LEVEL_CHARGING = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE      = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO      = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE    = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FOUR     = 3'd4;

endpackage

// File: sv/battery_level_gauge.sv
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// input     i_valid / o_stall  i_adc_sample, i_charger_present
// output    o_valid / i_stall  o_battery_level, o_charging, o_low_warning, o_average_value
// config    i_cfg_we           i_cfg_index, i_cfg_data
//
// One beat is accepted per cycle while o_stall is low. For each result,
// the window sum updates on accept, then mean, banding and warning are
// registered into the output stage. The first WINDOW beats give no result.
// Reset is synchronous; the sample ring itself is not cleared.
// A stalled output holds its beat; the middle stage still takes one more beat.
module battery_level_gauge
    import blg_pkg::*;
#(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ADC_W-1:0]     i_adc_sample,
    input  logic                 i_charger_present,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [LEVEL_W-1:0]   o_battery_level,
    output logic                 o_charging,
    output logic                 o_low_warning,
    output logic [AVG_W-1:0]     o_average_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + LOG_W;
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;

    // configuration
    logic [THR_W-1:0] r_full_thr;
    logic [THR_W-1:0] r_high_thr;
    logic [THR_W-1:0] r_mid_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_thr <= FULL_THR_RST;
            r_high_thr <= HIGH_THR_RST;
            r_mid_thr  <= MID_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FULL_THR: r_full_thr <= i_cfg_data;
                CFG_HIGH_THR: r_high_thr <= i_cfg_data;
                CFG_MID_THR:  r_mid_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic w_out_ready;
    logic w_mid_ready;
    logic w_accept;
    logic r_mid_valid;
    logic r_mid_charger;
    logic r_out_valid;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_mid_ready = !r_mid_valid || w_out_ready;
    assign w_accept    = i_valid && w_mid_ready;
    assign o_stall     = !w_mid_ready;

    // sample window
    logic             w_primed;
    logic [SUM_W-1:0] w_sum;

    blg_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_sample (SAMPLE_BITS'(i_adc_sample)),
        .o_primed (w_primed),
        .o_sum    (w_sum)
    );

    // middle stage: sum lives in the window, it only moves on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (w_mid_ready) begin
            r_mid_valid <= w_accept && w_primed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mid_charger <= i_charger_present;
        end
    end

    // mean by reciprocal multiply, exact for every sum value
    logic [PROD_W-1:0]      w_prod;
    logic [SAMPLE_BITS-1:0] w_mean;
    logic [CMP_W-1:0]       w_mean_c;
    logic [LEVEL_W-1:0]     w_level;

    assign w_prod   = PROD_W'(w_sum) * PROD_W'(RCP_W'(RECIP));
    assign w_mean   = w_prod[SHIFT +: SAMPLE_BITS];
    assign w_mean_c = CMP_W'(w_mean);

    // banding, first true test wins
    always_comb begin
        if (w_mean_c > CMP_W'(r_full_thr)) begin
            w_level = LEVEL_FOUR;
        end else if (w_mean_c > CMP_W'(r_high_thr)) begin
            w_level = LEVEL_THREE;
        end else if (w_mean_c > CMP_W'(r_mid_thr)) begin
            w_level = LEVEL_TWO;
        end else begin
            w_level = LEVEL_ONE;
        end
    end

    // output stage
    logic               r_warned;
    logic               n_warn;
    logic [LEVEL_W-1:0] r_level;
    logic               r_charging;
    logic               r_warn;
    logic [AVG_W-1:0]   r_avg;

    assign n_warn = r_mid_valid && !r_mid_charger && (w_level == LEVEL_ONE) && !r_warned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_warned    <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_mid_valid;
            if (n_warn) begin
                r_warned <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_mid_valid) begin
            r_level    <= r_mid_charger ? LEVEL_CHARGING : w_level;
            r_charging <= r_mid_charger;
            r_warn     <= n_warn;
            r_avg      <= AVG_W'(w_mean);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_battery_level = r_level;
    assign o_charging      = r_charging;
    assign o_low_warning   = r_warn;
    assign o_average_value = r_avg;

endmodule

// File: sv/blg_window.sv
`timescale 1ns / 1ps

// Ring of the most recent samples with a running sum.
// o_sum holds the sum including the last loaded sample.
module blg_window #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_load,
    input  logic [SAMPLE_BITS-1:0]                     i_sample,
    output logic                                       o_primed,
    output logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]      o_sum
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];
    logic [SLOT_W-1:0]      r_slot;
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_sum;

    logic [SLOT_W-1:0]      n_slot;
    logic [SUM_W-1:0]       n_sum;
    logic                   w_primed;
    logic [SAMPLE_BITS-1:0] w_old;

    // entries are only read once every slot has been written
    assign w_primed = (r_count == CNT_W'(WINDOW));
    assign w_old    = w_primed ? r_ring[r_slot] : '0;
    assign n_sum    = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);
    assign n_slot   = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_load) begin
            r_slot <= n_slot;
            r_sum  <= n_sum;
            if (!w_primed) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // sample storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ring[r_slot] <= i_sample;
        end
    end

    assign o_primed = w_primed;
    assign o_sum    = r_sum;

endmodule
